// ----- design/tpom_pkg.sv -----
// Shared constants, types and the coefficient ROM of the true-peak meter.
// No dependencies; imported by every other file of the block.

package tpom_pkg;

   localparam int OVERSAMPLE     = 4;
   localparam int TAPS_PER_PHASE = 12;
   localparam int MAX_CHANNELS   = 8;
   localparam int FLT_LEN        = OVERSAMPLE * TAPS_PER_PHASE;

   localparam int CH_W      = 3;
   localparam int SAMPLE_W  = 24;
   localparam int LEVEL_W   = 25;
   localparam int NUM_CH_W  = 4;
   localparam int COEF_W    = 18;
   localparam int PHASE_W   = $clog2(OVERSAMPLE);
   localparam int TAP_W     = $clog2(TAPS_PER_PHASE);
   localparam int ROM_AW    = $clog2(FLT_LEN);
   localparam int HIST_DEPTH = MAX_CHANNELS * TAPS_PER_PHASE;
   localparam int HIST_AW   = $clog2(HIST_DEPTH);
   localparam int PROD_W    = COEF_W + SAMPLE_W;
   localparam int ACC_W     = PROD_W + $clog2(TAPS_PER_PHASE);
   localparam int RND_SHIFT = 16;
   localparam int RND_W     = ACC_W + 1 - RND_SHIFT;

   localparam logic [NUM_CH_W-1:0] NUM_CH_RESET = NUM_CH_W'(2);
   localparam logic [LEVEL_W-1:0]  PEAK_MAX     = '1;

   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint PI_Q30   = 64'sd3373259426;
   localparam longint BETA_Q30 = 64'sd9234179686;
   localparam longint COEF_MAX = (longint'(1) << (COEF_W - 1)) - 1;
   localparam longint COEF_MIN = -(longint'(1) << (COEF_W - 1));

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [FLT_LEN-1:0][COEF_W-1:0] coef_rom_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic                clr;
      logic                wr_en;
      logic [HIST_AW-1:0]  wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic                rd_en;
      logic [HIST_AW-1:0]  rd_addr;
   } hist_cmd_type;

   typedef struct packed {
      logic               valid;
      logic [PHASE_W-1:0] phase;
      logic [TAP_W-1:0]   tap;
      logic               last_tap;
      logic               last_phase;
   } tap_ctrl_type;

   typedef struct packed {
      logic               valid;
      logic               final_phase;
      logic [LEVEL_W-1:0] level;
   } mag_result_type;

   // Q30 helpers, used only to build the ROM at elaboration
   function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return ((a * (b >> 15)) >> 15) + ((a * (b & 64'h7fff)) >> 30);
   endfunction

   // restoring shift-subtract division, quotient only
   function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
      longint unsigned quo;
      longint unsigned rem;
      int              i;
      quo = 0;
      rem = 0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n[i]};
         if (rem >= d) begin
            rem    = rem - d;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint div_round(longint n, longint d);
      longint nn;
      longint dv;
      nn = n;
      dv = d;
      if (dv < 0) begin
         nn = -nn;
         dv = -dv;
      end
      if (nn >= 0) begin
         return longint'(udiv64(nn + dv / 2, dv));
      end
      return -longint'(udiv64(-nn + dv / 2, dv));
   endfunction

   function automatic longint unsigned isqrt64(longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bitv;
      rem  = v;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) begin
         bitv = bitv >> 2;
      end
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // I0(2h), h in Q30, result in Q30
   function automatic longint unsigned bessel_i0(longint unsigned h);
      longint unsigned y;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned kk;
      logic            done;
      y    = mul_q30(h, h);
      sum  = longint'(ONE_Q30);
      term = longint'(ONE_Q30);
      done = 1'b0;
      for (kk = 1; kk < 64; kk++) begin
         if (!done) begin
            term = udiv64(mul_q30(term, y), kk * kk);
            if (term == 0) begin
               done = 1'b1;
            end else begin
               sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic longint taylor(longint unsigned th, logic odd);
      longint unsigned t2;
      longint unsigned term;
      longint unsigned j;
      longint          sum;
      logic            neg;
      t2   = mul_q30(th, th);
      term = odd ? th : longint'(ONE_Q30);
      j    = odd ? 64'd2 : 64'd1;
      sum  = longint'(term);
      neg  = 1'b1;
      while (term != 0) begin
         term = udiv64(mul_q30(term, t2), j * (j + 1));
         j    = j + 2;
         sum  = neg ? sum - longint'(term) : sum + longint'(term);
         neg  = !neg;
      end
      return sum;
   endfunction

   function automatic longint sin_units(longint unsigned a);
      longint unsigned q;
      longint          r;
      longint          th;
      longint          v;
      q  = (a / OVERSAMPLE) & 64'd3;
      r  = longint'(a % OVERSAMPLE);
      th = div_round(PI_Q30 * r, longint'(2 * OVERSAMPLE));
      v  = taylor(longint'(th), q[0] == 1'b0);
      return (q >= 2) ? -v : v;
   endfunction

   function automatic coef_rom_type build_coef_rom();
      longint          taps [FLT_LEN];
      longint          dd;
      longint          i0b;
      longint          m;
      longint          sinc;
      longint          num;
      longint          q;
      longint          r;
      longint          sum;
      longint          sgn;
      longint          d;
      longint          t;
      longint          c;
      longint unsigned f60;
      longint unsigned s;
      longint unsigned h;
      coef_rom_type    rom;
      int              n;
      int              p;
      int              k;
      rom = '0;
      dd  = longint'(FLT_LEN - 1) * longint'(FLT_LEN - 1);
      i0b = longint'(bessel_i0(longint'(BETA_Q30) >> 1) >> 12);
      for (n = 0; n < FLT_LEN; n++) begin
         m = 2 * longint'(n) - longint'(FLT_LEN - 1);
         if (m < 0) begin
            m = -m;
         end
         if (m == 0) begin
            sinc = ONE_Q30;
         end else begin
            sinc = div_round(sin_units(longint'(m)) * ONE_Q30,
                             div_round(PI_Q30 * m, longint'(2 * OVERSAMPLE)));
         end
         num = dd - m * m;
         q   = longint'(udiv64(num * ONE_Q30, dd));
         r   = num * ONE_Q30 - q * dd;
         f60 = (longint'(q) << 30) + udiv64(r * ONE_Q30, dd);
         s   = isqrt64(f60);
         h   = mul_q30(longint'(BETA_Q30), s) >> 1;
         taps[n] = sinc * longint'(bessel_i0(h) >> 12);
      end
      for (p = 0; p < OVERSAMPLE; p++) begin
         sum = 0;
         sgn = 1;
         for (k = 0; k < TAPS_PER_PHASE; k++) begin
            sum = sum + taps[k * OVERSAMPLE + p];
         end
         if (sum < 0) begin
            sum = -sum;
            sgn = -1;
         end
         d = sum >>> 16;
         for (k = 0; k < TAPS_PER_PHASE; k++) begin
            t = taps[k * OVERSAMPLE + p];
            c = (d > 0) ? div_round(sgn * t, d) : div_round(t, i0b * 16384);
            if (c > COEF_MAX) begin
               c = COEF_MAX;
            end
            if (c < COEF_MIN) begin
               c = COEF_MIN;
            end
            rom[p * TAPS_PER_PHASE + k] = c[COEF_W-1:0];
         end
      end
      return rom;
   endfunction

   // phase p, tap k at entry p*TAPS_PER_PHASE+k, Q2.16
   localparam coef_rom_type COEF_ROM = build_coef_rom();

endpackage

// ----- design/tpom_if.sv -----
// Valid/ready channel interfaces of the true-peak meter: sample requests and peak responses.
// Depends on tpom_pkg.

interface tpom_req_if
   import tpom_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CH_W-1:0]            channel;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       clear;

   modport source (output valid, output channel, output sample, output clear, input ready);
   modport sink   (input valid, input channel, input sample, input clear, output ready);
endinterface

interface tpom_rsp_if
   import tpom_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] peak_level;

   modport source (output valid, output peak_level, input ready);
   modport sink   (input valid, input peak_level, output ready);
endinterface

// ----- design/true_peak_oversampled_meter.sv -----
// True-peak meter with 4x polyphase oversampling: one sample transaction in, one
// running-peak transaction out, per transaction taken. A sample for an active channel
// is handled in order: on acceptance it is written into the history memory, then the
// single 18x24 multiplier is driven one tap per cycle (12 taps times 4 phases, read one
// per cycle from the history memory), then the MAC pipeline drains and the peak is handed
// to the output register. Clear transactions and samples for unused channels go straight
// to offering the result. Histories are cleared at once by per-entry flags, so there is
// no clearing pass after reset. Writing num_channels clears all histories and the peak.
// The output register lets the next sample be taken while a result still waits. Depends
// on tpom_pkg and tpom_if.

module true_peak_oversampled_meter
   import tpom_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   tpom_req_if.sink            req_chan,
   tpom_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  logic [NUM_CH_W-1:0] csr_write_data
);

   hist_cmd_type               hist_cmd;
   tap_ctrl_type               tap_ctrl;
   mag_result_type             mag;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic                       seq_result_valid;
   logic [LEVEL_W-1:0]         seq_result_level;
   logic                       result_taken;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [LEVEL_W-1:0]         rsp_level_ff;

   tpom_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_channel      (req_chan.channel),
      .req_sample       (req_chan.sample),
      .req_clear        (req_chan.clear),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .hist_cmd         (hist_cmd),
      .tap_ctrl         (tap_ctrl),
      .mag              (mag),
      .result_valid     (seq_result_valid),
      .result_level     (seq_result_level),
      .result_taken     (result_taken)
   );

   tpom_hist_mem u_hist_mem (
      .clock     (clock),
      .reset     (reset),
      .hist_cmd  (hist_cmd),
      .rd_sample (rd_sample)
   );

   tpom_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .tap_ctrl  (tap_ctrl),
      .rd_sample (rd_sample),
      .mag       (mag)
   );

   assign result_taken = seq_result_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_taken) begin
         rsp_level_ff <= seq_result_level;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.peak_level = rsp_level_ff;

   a_write_then_newest_tap: assert property (@(posedge clock) disable iff (reset)
      hist_cmd.wr_en |=> tap_ctrl.valid && (tap_ctrl.phase == '0) && (tap_ctrl.tap == '0))
      else $error("first tap read does not follow history write");

   a_final_phase_to_result: assert property (@(posedge clock) disable iff (reset)
      mag.valid && mag.final_phase |=> seq_result_valid)
      else $error("result not offered after last phase");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      tap_ctrl.valid |-> !req_chan.ready)
      else $error("request ready while MAC sequence running");

endmodule

// ----- design/tpom_hist_mem.sv -----
// Sample history memory: all channels' circular histories, registered read.
// Per-entry live flags make cleared entries read as zero. Depends on tpom_pkg.

module tpom_hist_mem
   import tpom_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  hist_cmd_type               hist_cmd,
   output logic signed [SAMPLE_W-1:0] rd_sample
);

   logic [SAMPLE_W-1:0]   hist_mem_ff [HIST_DEPTH];
   logic [HIST_DEPTH-1:0] live_ff;
   logic [SAMPLE_W-1:0]   rd_word_ff;
   logic                  rd_live_ff;

   always_ff @(posedge clock) begin
      if (hist_cmd.wr_en) begin
         hist_mem_ff[hist_cmd.wr_addr] <= hist_cmd.wr_data;
      end
      if (hist_cmd.rd_en) begin
         rd_word_ff <= hist_mem_ff[hist_cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         if (hist_cmd.clr) begin
            live_ff <= '0;
         end else if (hist_cmd.wr_en) begin
            live_ff[hist_cmd.wr_addr] <= 1'b1;
         end
         if (hist_cmd.rd_en) begin
            rd_live_ff <= live_ff[hist_cmd.rd_addr];
         end
      end
   end

   assign rd_sample = rd_live_ff ? $signed(rd_word_ff) : '0;

endmodule

// ----- design/tpom_mac.sv -----
// Shared multiply-accumulate pipeline: coefficient ROM, 18x24 multiplier, accumulator,
// magnitude rounding and saturation per phase. Depends on tpom_pkg.

module tpom_mac
   import tpom_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  tap_ctrl_type               tap_ctrl,
   input  logic signed [SAMPLE_W-1:0] rd_sample,
   output mag_result_type             mag
);

   tap_ctrl_type             s1_ff;
   tap_ctrl_type             s2_ff;
   tap_ctrl_type             s3_ff;
   logic [ROM_AW-1:0]        rom_idx;
   coef_type                 coef;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]         abs_val;
   logic [ACC_W:0]           rnd_sum;
   logic [RND_W-1:0]         rnd_q;
   logic [LEVEL_W-1:0]       level_in;
   logic [LEVEL_W-1:0]       level_ff;
   logic                     mag_valid_ff;
   logic                     final_ff;

   always_comb begin
      rom_idx = ROM_AW'(s1_ff.phase) * ROM_AW'(TAPS_PER_PHASE) + ROM_AW'(s1_ff.tap);
      coef    = $signed(COEF_ROM[rom_idx]);
      prod_in = coef * rd_sample;
      if (s2_ff.tap == '0) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      abs_val = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      rnd_sum = (ACC_W + 1)'(abs_val) + (ACC_W + 1)'(1 << (RND_SHIFT - 1));
      rnd_q   = rnd_sum[ACC_W:RND_SHIFT];
      if (rnd_q > RND_W'(PEAK_MAX)) begin
         level_in = PEAK_MAX;
      end else begin
         level_in = rnd_q[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         mag_valid_ff <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         s1_ff        <= tap_ctrl;
         s2_ff        <= s1_ff;
         s3_ff        <= s2_ff;
         mag_valid_ff <= s3_ff.valid && s3_ff.last_tap;
         final_ff     <= s3_ff.last_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (s3_ff.valid && s3_ff.last_tap) begin
         level_ff <= level_in;
      end
   end

   assign mag.valid       = mag_valid_ff;
   assign mag.final_phase = final_ff;
   assign mag.level       = level_ff;

endmodule

// ----- design/tpom_seq.sv -----
// Sequencer: takes transactions, writes the history, steps phase and tap through
// the MAC pipeline, holds write positions, channel count and running peak. Depends on tpom_pkg.

module tpom_seq
   import tpom_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CH_W-1:0]            req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_clear,
   input  logic                       csr_write_enable,
   input  logic [NUM_CH_W-1:0]        csr_write_data,
   output hist_cmd_type               hist_cmd,
   output tap_ctrl_type               tap_ctrl,
   input  mag_result_type             mag,
   output logic                       result_valid,
   output logic [LEVEL_W-1:0]         result_level,
   input  logic                       result_taken
);

   seq_state_type        state_ff;
   seq_state_type        state_in;
   logic [NUM_CH_W-1:0]  num_ch_ff;
   logic [NUM_CH_W-1:0]  num_ch_in;
   logic [TAP_W-1:0]     wpos_ff [MAX_CHANNELS];
   logic [TAP_W-1:0]     wpos_in [MAX_CHANNELS];
   logic [LEVEL_W-1:0]   peak_ff;
   logic [LEVEL_W-1:0]   peak_in;
   logic [CH_W-1:0]      ch_ff;
   logic [CH_W-1:0]      ch_in;
   logic [TAP_W-1:0]     base_ff;
   logic [TAP_W-1:0]     base_in;
   logic [TAP_W-1:0]     idx_ff;
   logic [TAP_W-1:0]     idx_in;
   logic [PHASE_W-1:0]   phase_ff;
   logic [PHASE_W-1:0]   phase_in;
   logic [TAP_W-1:0]     tap_ff;
   logic [TAP_W-1:0]     tap_in;

   logic [NUM_CH_W-1:0]  active_ch;
   logic                 ch_live;
   logic                 accept;
   logic                 clear_all;
   logic [TAP_W-1:0]     cur_pos;
   logic [TAP_W-1:0]     next_pos;
   logic                 last_tap;
   logic                 last_phase;

   always_comb begin
      priority if (num_ch_ff == '0) begin
         active_ch = NUM_CH_W'(1);
      end else if (num_ch_ff > NUM_CH_W'(MAX_CHANNELS)) begin
         active_ch = NUM_CH_W'(MAX_CHANNELS);
      end else begin
         active_ch = num_ch_ff;
      end
      ch_live    = NUM_CH_W'(req_channel) < active_ch;
      cur_pos    = wpos_ff[req_channel];
      next_pos   = (cur_pos == TAP_W'(TAPS_PER_PHASE - 1)) ? '0 : cur_pos + TAP_W'(1);
      last_tap   = tap_ff == TAP_W'(TAPS_PER_PHASE - 1);
      last_phase = phase_ff == PHASE_W'(OVERSAMPLE - 1);
   end

   always_comb begin
      state_in     = state_ff;
      num_ch_in    = num_ch_ff;
      wpos_in      = wpos_ff;
      peak_in      = peak_ff;
      ch_in        = ch_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      tap_in       = tap_ff;
      hist_cmd     = '0;
      tap_ctrl     = '0;
      req_ready    = 1'b0;
      result_valid = 1'b0;
      clear_all    = 1'b0;
      accept       = 1'b0;

      if (mag.valid && (mag.level > peak_ff)) begin
         peak_in = mag.level;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               priority if (req_clear) begin
                  clear_all = 1'b1;
                  state_in  = ST_FINISH;
               end else if (ch_live) begin
                  hist_cmd.wr_en   = 1'b1;
                  hist_cmd.wr_addr = HIST_AW'(req_channel) * HIST_AW'(TAPS_PER_PHASE)
                                   + HIST_AW'(cur_pos);
                  hist_cmd.wr_data = req_sample;
                  wpos_in[req_channel] = next_pos;
                  ch_in    = req_channel;
                  base_in  = cur_pos;
                  idx_in   = cur_pos;
                  phase_in = '0;
                  tap_in   = '0;
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_RUN: begin
            hist_cmd.rd_en      = 1'b1;
            hist_cmd.rd_addr    = HIST_AW'(ch_ff) * HIST_AW'(TAPS_PER_PHASE) + HIST_AW'(idx_ff);
            tap_ctrl.valid      = 1'b1;
            tap_ctrl.phase      = phase_ff;
            tap_ctrl.tap        = tap_ff;
            tap_ctrl.last_tap   = last_tap;
            tap_ctrl.last_phase = last_phase;
            if (last_tap) begin
               tap_in = '0;
               idx_in = base_ff;
               if (last_phase) begin
                  state_in = ST_DRAIN;
               end else begin
                  phase_in = phase_ff + PHASE_W'(1);
               end
            end else begin
               tap_in = tap_ff + TAP_W'(1);
               idx_in = (idx_ff == '0) ? TAP_W'(TAPS_PER_PHASE - 1) : idx_ff - TAP_W'(1);
            end
         end
         ST_DRAIN: begin
            if (mag.valid && mag.final_phase) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            result_valid = 1'b1;
            if (result_taken) begin
               state_in = ST_IDLE;
            end
         end
      endcase

      if (csr_write_enable) begin
         num_ch_in = csr_write_data;
         clear_all = 1'b1;
      end
      if (clear_all) begin
         hist_cmd.clr = 1'b1;
         wpos_in      = '{default: '0};
         peak_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         num_ch_ff <= NUM_CH_RESET;
         wpos_ff   <= '{default: '0};
         peak_ff   <= '0;
         phase_ff  <= '0;
         tap_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         num_ch_ff <= num_ch_in;
         wpos_ff   <= wpos_in;
         peak_ff   <= peak_in;
         phase_ff  <= phase_in;
         tap_ff    <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      base_ff <= base_in;
      idx_ff  <= idx_in;
   end

   assign result_level = peak_ff;

endmodule
